>>> design/phfa_pkg.sv
package phfa_pkg;

	// widest field and the byte window it can touch (field plus worst bit phase)
	localparam int MAX_FIELD_BITS = 32;
	localparam int WIN_BYTES      = (MAX_FIELD_BITS + 7 + 7) / 8;
	localparam int WIN_BITS       = WIN_BYTES * 8;
	localparam int NB_W           = $clog2(WIN_BYTES + 1);

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [4:0] DROP_SLOT_RST   = 5'd31;
	localparam logic [9:0] DROP_OFFSET_RST = 10'd9;
	localparam logic [5:0] DROP_LENGTH_RST = 6'd9;

	typedef enum logic [2:0] {
		ACT_LOAD_BYTE   = 3'd0,
		ACT_SET_HDR     = 3'd1,
		ACT_READ_FIELD  = 3'd2,
		ACT_WRITE_FIELD = 3'd3,
		ACT_DROP        = 3'd4,
		ACT_READ_BYTE   = 3'd5
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DROP_SLOT   = 2'd0,
		CFG_DROP_OFFSET = 2'd1,
		CFG_DROP_LENGTH = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SETUP,
		ST_PREP,
		ST_BYTES,
		ST_DRAIN,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [7:0]  byte_index;
		logic [7:0]  byte_data;
		logic [4:0]  header_slot;
		logic [10:0] header_start_bit;
		logic [9:0]  field_bit_offset;
		logic [5:0]  field_length;
		logic [31:0] write_value;
	} item_t;

	typedef struct packed {
		logic [31:0] field_value;
		logic [7:0]  byte_value;
		logic        out_of_range;
	} result_t;

	typedef struct packed {
		logic capture;
		logic decode;
		logic setup;
		logic prep;
		logic issue;
		logic consume;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [2:0]      action;
		logic            fits;
		logic [NB_W-1:0] nbytes;
	} ctrl_stat_t;

endpackage

>>> design/phfa_if.sv
interface phfa_item_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [7:0]  byte_index;
	logic [7:0]  byte_data;
	logic [4:0]  header_slot;
	logic [10:0] header_start_bit;
	logic [9:0]  field_bit_offset;
	logic [5:0]  field_length;
	logic [31:0] write_value;

	modport source (output valid, action, byte_index, byte_data, header_slot,
		header_start_bit, field_bit_offset, field_length, write_value, input ready);
	modport sink (input valid, action, byte_index, byte_data, header_slot,
		header_start_bit, field_bit_offset, field_length, write_value, output ready);
endinterface

interface phfa_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] field_value;
	logic [7:0]  byte_value;
	logic        out_of_range;

	modport source (output valid, field_value, byte_value, out_of_range, input ready);
	modport sink (input valid, field_value, byte_value, out_of_range, output ready);
endinterface

interface phfa_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> design/phfa_ram.sv
module phfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                      wr_data,
	input  logic                                  rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> design/phfa_ctrl.sv
module phfa_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_ready,
	output logic                   result_valid,
	input  logic                   result_ready,
	output phfa_pkg::ctrl_cmd_t    cmd,
	input  phfa_pkg::ctrl_stat_t   stat
);

	import phfa_pkg::*;

	state_t          state_q, state_d;
	logic [NB_W-1:0] cnt_q;
	logic            cnt_clr, cnt_inc;
	logic            out_valid_q;
	logic            out_free;

	assign out_free     = !out_valid_q || result_ready;
	assign result_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cnt_clr) begin
				cnt_q <= '0;
			end else if (cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		cnt_clr    = 1'b0;
		cnt_inc    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.decode = 1'b1;
				case (stat.action) inside
					ACT_READ_FIELD, ACT_WRITE_FIELD, ACT_DROP: state_d = ST_SETUP;
					default:                                   state_d = ST_RESULT;
				endcase
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				cnt_clr  = 1'b1;
				if (stat.fits && stat.nbytes != '0) begin
					state_d = ST_BYTES;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_BYTES: begin
				// read byte n while byte n-1 is merged or shifted in
				cmd.issue   = 1'b1;
				cmd.consume = (cnt_q != '0);
				cnt_inc     = 1'b1;
				if (cnt_q == stat.nbytes - 1'b1) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				cmd.consume = 1'b1;
				state_d     = ST_RESULT;
			end
			ST_RESULT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> design/phfa_dpath.sv
module phfa_dpath #(
	parameter int PACKET_BYTES = 256,
	parameter int HEADER_SLOTS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  phfa_pkg::item_t                     item_d,
	input  logic                                cfg_wr,
	input  logic [phfa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [phfa_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  phfa_pkg::ctrl_cmd_t                 cmd,
	output phfa_pkg::ctrl_stat_t                stat,
	output phfa_pkg::result_t                   res
);

	import phfa_pkg::*;

	localparam int          AW         = PACKET_BYTES > 1 ? $clog2(PACKET_BYTES) : 1;
	localparam int          SLOT_W     = HEADER_SLOTS > 1 ? $clog2(HEADER_SLOTS) : 1;
	localparam logic [31:0] BITS_TOTAL = 32'(PACKET_BYTES * 8);
	localparam logic [31:0] BYTES_LIM  = 32'(PACKET_BYTES);

	// configuration
	logic [4:0] drop_slot_q;
	logic [9:0] drop_off_q;
	logic [5:0] drop_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_slot_q <= DROP_SLOT_RST;
			drop_off_q  <= DROP_OFFSET_RST;
			drop_len_q  <= DROP_LENGTH_RST;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				CFG_DROP_SLOT:   drop_slot_q <= cfg_data[4:0];
				CFG_DROP_OFFSET: drop_off_q  <= cfg_data[9:0];
				CFG_DROP_LENGTH: drop_len_q  <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// slot wrap, worked out at elaboration
	logic [SLOT_W-1:0] slot_map [32];
	for (genvar v = 0; v < 32; v++) begin : g_slot
		assign slot_map[v] = SLOT_W'(v % HEADER_SLOTS);
	end

	item_t item_q;
	logic  is_drop, is_rmw, idx_ok;
	logic  [AW-1:0] idx_addr;

	assign is_drop  = (item_q.action == ACT_DROP);
	assign is_rmw   = (item_q.action == ACT_WRITE_FIELD) || is_drop;
	assign idx_ok   = (32'(item_q.byte_index) < BYTES_LIM);
	assign idx_addr = AW'(item_q.byte_index);

	// header start table with per-slot valid bits
	logic [HEADER_SLOTS-1:0] hvalid_q;
	logic [SLOT_W-1:0]       tbl_raddr, tbl_waddr;
	logic                    tbl_we;
	logic [10:0]             tbl_rd;
	logic                    hit_q;

	assign tbl_raddr = slot_map[is_drop ? drop_slot_q : item_q.header_slot];
	assign tbl_waddr = slot_map[item_q.header_slot];
	assign tbl_we    = cmd.decode && (item_q.action == ACT_SET_HDR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hvalid_q <= '0;
		end else if (tbl_we) begin
			hvalid_q[tbl_waddr] <= 1'b1;
		end
	end

	phfa_ram #(.WIDTH(11), .DEPTH(HEADER_SLOTS)) u_hdr_tbl (
		.clk     (clk),
		.wr_en   (tbl_we),
		.wr_addr (tbl_waddr),
		.wr_data (item_q.header_start_bit),
		.rd_en   (cmd.decode),
		.rd_addr (tbl_raddr),
		.rd_data (tbl_rd)
	);

	// field geometry
	logic [11:0]           start_q;
	logic [5:0]            len_q;
	logic                  fits_q;
	logic [NB_W-1:0]       nbytes_q;
	logic [31:0]           value_q;
	logic [31:0]           mask_q;
	logic [2:0]            trail_q;
	logic [WIN_BITS-1:0]   wbits_q, mbits_q, acc_q;
	logic [AW-1:0]         rptr_q, wptr_q;

	logic [10:0]           hstart;
	logic [9:0]            off_sel;
	logic [5:0]            len_raw, len_cl;
	logic [11:0]           start_c;
	logic [12:0]           end_c;
	logic [6:0]            span_c;
	logic [2:0]            phase;
	logic [31:0]           mask_c;
	logic [5:0]            sh_c;
	logic [5:0]            trail_c;

	assign hstart  = hit_q ? tbl_rd : '0;
	assign off_sel = is_drop ? drop_off_q : item_q.field_bit_offset;
	assign len_raw = is_drop ? drop_len_q : item_q.field_length;
	assign len_cl  = (len_raw > 6'(MAX_FIELD_BITS)) ? 6'(MAX_FIELD_BITS) : len_raw;
	assign start_c = 12'(hstart) + 12'(off_sel);
	assign end_c   = 13'(start_c) + 13'(len_cl);
	assign span_c  = 7'(start_c[2:0]) + 7'(len_cl) + 7'd7;

	assign phase   = start_q[2:0];
	assign mask_c  = 32'((33'd1 << len_q) - 33'd1);
	assign sh_c    = 6'(WIN_BITS) - len_q - 6'(phase);
	assign trail_c = {nbytes_q, 3'b000} - 6'(phase) - len_q;

	// packet store
	logic            pkt_we, pkt_re;
	logic [AW-1:0]   pkt_waddr, pkt_raddr;
	logic [7:0]      pkt_wdata, pkt_rd, merged;
	logic [7:0]      mtop, wtop;

	assign mtop      = mbits_q[WIN_BITS-1 -: 8];
	assign wtop      = wbits_q[WIN_BITS-1 -: 8];
	assign merged    = (pkt_rd & ~mtop) | (wtop & mtop);
	assign pkt_we    = (cmd.decode && item_q.action == ACT_LOAD_BYTE && idx_ok)
		|| (cmd.consume && is_rmw);
	assign pkt_waddr = cmd.consume ? wptr_q : idx_addr;
	assign pkt_wdata = cmd.consume ? merged : item_q.byte_data;
	assign pkt_re    = (cmd.decode && item_q.action == ACT_READ_BYTE && idx_ok) || cmd.issue;
	assign pkt_raddr = cmd.issue ? rptr_q : idx_addr;

	phfa_ram #(.WIDTH(8), .DEPTH(PACKET_BYTES)) u_pkt_store (
		.clk     (clk),
		.wr_en   (pkt_we),
		.wr_addr (pkt_waddr),
		.wr_data (pkt_wdata),
		.rd_en   (pkt_re),
		.rd_addr (pkt_raddr),
		.rd_data (pkt_rd)
	);

	result_t res_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item_d;
		end
		if (cmd.decode) begin
			hit_q <= hvalid_q[tbl_raddr];
		end
		if (cmd.setup) begin
			start_q  <= start_c;
			len_q    <= len_cl;
			fits_q   <= (32'(end_c) <= BITS_TOTAL);
			nbytes_q <= (len_cl == '0) ? '0 : NB_W'(span_c >> 3);
			value_q  <= is_drop ? '0 : item_q.write_value;
		end
		if (cmd.prep) begin
			mask_q  <= mask_c;
			trail_q <= trail_c[2:0];
			wbits_q <= WIN_BITS'(value_q & mask_c) << sh_c;
			mbits_q <= WIN_BITS'(mask_c) << sh_c;
			rptr_q  <= AW'(start_q >> 3);
			wptr_q  <= AW'(start_q >> 3);
		end
		if (cmd.issue) begin
			rptr_q <= rptr_q + 1'b1;
		end
		if (cmd.consume) begin
			acc_q   <= {acc_q[WIN_BITS-9:0], pkt_rd};
			wbits_q <= wbits_q << 8;
			mbits_q <= mbits_q << 8;
			wptr_q  <= wptr_q + 1'b1;
		end
		if (cmd.load_out) begin
			res_q.field_value  <= (item_q.action == ACT_READ_FIELD && fits_q)
				? (32'(acc_q >> trail_q) & mask_q) : '0;
			res_q.byte_value   <= (item_q.action == ACT_READ_BYTE && idx_ok) ? pkt_rd : '0;
			res_q.out_of_range <= (item_q.action == ACT_READ_FIELD
				|| item_q.action == ACT_WRITE_FIELD || is_drop) && !fits_q;
		end
	end

	assign res         = res_q;
	assign stat.action = item_q.action;
	assign stat.fits   = fits_q;
	assign stat.nbytes = nbytes_q;

endmodule

>>> design/packet_header_field_access.sv
// Packet header field access. Keeps a byte-wide packet store and a table of
// header start bit positions, one per header slot, and takes one word per
// action on the item channel: load a byte, set a header start, read a field,
// write a field, drop (zero the egress field named by the three drop
// registers) or read back a byte. Fields are 1 to 32 bits, big-endian, bit 7
// of a byte first, at header start plus a bit offset; longer lengths are cut
// to 32 and a zero length is an empty field. A field that runs past the end
// of the store gives out_of_range and writes nothing. Every item gives exactly
// one result word. Load, set, byte read and unused actions go from acceptance
// through decode to the result; a field action goes through setup and prep,
// then, unless it is out of range or empty, passes over the 1 to 5 bytes it
// touches, one byte per cycle with reads and read-modify-writes overlapped on
// the store's separate byte read and write ports. The store is not
// cleared at reset and bytes must be loaded before they are read; the header
// table reads as zero after reset through per-slot valid bits, with no
// clearing pass. A new word is taken while the previous result still waits in
// the output register. Configuration writes are always ready and are meant
// to be made while no item is in flight.
module packet_header_field_access #(
	parameter int PACKET_BYTES = 256,
	parameter int HEADER_SLOTS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	phfa_cfg_if.sink     cfg,
	phfa_item_if.sink    item,
	phfa_result_if.source result
);

	import phfa_pkg::*;

	item_t      item_d;
	result_t    res;
	ctrl_cmd_t  cmd;
	ctrl_stat_t stat;

	// gather the item word
	assign item_d.action           = item.action;
	assign item_d.byte_index       = item.byte_index;
	assign item_d.byte_data        = item.byte_data;
	assign item_d.header_slot      = item.header_slot;
	assign item_d.header_start_bit = item.header_start_bit;
	assign item_d.field_bit_offset = item.field_bit_offset;
	assign item_d.field_length     = item.field_length;
	assign item_d.write_value      = item.write_value;

	// registers take a write every cycle
	assign cfg.ready = 1'b1;

	phfa_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_ready   (item.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.cmd          (cmd),
		.stat         (stat)
	);

	phfa_dpath #(
		.PACKET_BYTES (PACKET_BYTES),
		.HEADER_SLOTS (HEADER_SLOTS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_d    (item_d),
		.cfg_wr    (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.cmd       (cmd),
		.stat      (stat),
		.res       (res)
	);

	// result word from the output register
	assign result.field_value  = res.field_value;
	assign result.byte_value   = res.byte_value;
	assign result.out_of_range = res.out_of_range;

endmodule

>>> design/phfa_checker.sv
module phfa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic [31:0] field_value,
	input logic [7:0]  byte_value,
	input logic        out_of_range
);

	logic [1:0] pend_q;

	// words taken but whose result has not yet gone out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(item_valid && item_ready) - 2'(result_valid && result_ready);
		end
	end

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(field_value)
			&& $stable(byte_value) && $stable(out_of_range))
		else $error("result word changed while stalled");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 2'd2)
		else $error("more than two words in flight");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pend_q != 2'd0)
		else $error("result without an accepted word");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && out_of_range |-> field_value == 32'd0 && byte_value == 8'd0)
		else $error("out of range result carries data");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> field_value == 32'd0 || byte_value == 8'd0)
		else $error("field and byte both set");

endmodule

bind packet_header_field_access phfa_checker u_phfa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.field_value  (result.field_value),
	.byte_value   (result.byte_value),
	.out_of_range (result.out_of_range)
);
